/* rtl/cfe_pkg.sv */
// package for the command frame encoder with crc-16
// holds item types, frame constants and the crc byte update; no dependencies
package cfe_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned CrcW          = 16;
  localparam int unsigned MaxPayloadDef = 8;
  localparam int unsigned BurstMax      = 8;
  localparam int unsigned CntW          = $clog2(BurstMax + 1);

  localparam logic [ByteW-1:0] FrameHead  = 8'h02;
  localparam logic [ByteW-1:0] MasterByte = 8'h00;
  localparam logic [ByteW-1:0] PadByte    = 8'h00;
  localparam logic [CrcW-1:0]  CrcPoly    = 16'h1021;
  localparam logic [CrcW-1:0]  CrcInit    = 16'h0000;

  // bytes of one item's output run, slot 0 goes out first
  typedef struct packed {
    logic [BurstMax-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                count;
    logic                           close;
  } burst_t;

  // crc-16, msb first, no reflection
  function automatic logic [CrcW-1:0] crc_add_byte(logic [CrcW-1:0] crc,
                                                   logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CrcW-1]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/cfe_if.sv */
// valid/ready channel interfaces for the command frame encoder
// input item channel and frame byte channel; uses cfe_pkg for widths
interface cfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [cfe_pkg::ByteW-1:0]     command;
  logic [cfe_pkg::LenW-1:0]      payload_length;
  logic [cfe_pkg::ByteW-1:0]     payload_byte;
  logic                          first_item;
  logic                          last_item;

  modport source (output valid, command, payload_length, payload_byte, first_item,
                  last_item, input ready);
  modport sink (input valid, command, payload_length, payload_byte, first_item,
                last_item, output ready);
endinterface

interface cfe_out_if;
  logic                      valid;
  logic                      ready;
  logic [cfe_pkg::ByteW-1:0] frame_byte;
  logic                      run_last;
  logic                      frame_last;

  modport source (output valid, frame_byte, run_last, frame_last, input ready);
  modport sink (input valid, frame_byte, run_last, frame_last, output ready);
endinterface

/* rtl/cfe_build.sv */
// builds the byte run of one item and keeps the running crc and frame state
// depends on cfe_pkg
module cfe_build #(
  parameter int unsigned MAX_PAYLOAD = cfe_pkg::MaxPayloadDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [cfe_pkg::ByteW-1:0] command_i,
  input  logic [cfe_pkg::LenW-1:0]  payload_length_i,
  input  logic [cfe_pkg::ByteW-1:0] payload_byte_i,
  input  logic                      first_item_i,
  input  logic                      last_item_i,
  output cfe_pkg::burst_t           burst_o
);
  import cfe_pkg::*;

  logic [CrcW-1:0] crc_q, crc_d;
  logic            in_frame_q, in_frame_d;
  logic [LenW-1:0] len_sat;
  logic [CrcW-1:0] crc_hdr, crc_pl, crc_run;
  logic            active;

  always_comb begin
    if (32'(payload_length_i) > MAX_PAYLOAD) begin
      len_sat = LenW'(MAX_PAYLOAD);
    end else begin
      len_sat = payload_length_i;
    end
  end

  always_comb begin
    crc_hdr = crc_add_byte(CrcInit, command_i);
    crc_hdr = crc_add_byte(crc_hdr, MasterByte);
    crc_hdr = crc_add_byte(crc_hdr, PadByte);
    crc_hdr = crc_add_byte(crc_hdr, {{(ByteW-LenW){1'b0}}, len_sat});
  end

  // payload byte folds into the header crc on a first item, the stored crc otherwise
  assign crc_pl = crc_add_byte(first_item_i ? crc_hdr : crc_q, payload_byte_i);

  always_comb begin
    burst_o = '0;
    crc_run = crc_pl;
    if (first_item_i) begin
      burst_o.bytes[0] = FrameHead;
      burst_o.bytes[1] = command_i;
      burst_o.bytes[2] = MasterByte;
      burst_o.bytes[3] = PadByte;
      burst_o.bytes[4] = {{(ByteW-LenW){1'b0}}, len_sat};
      if (len_sat != '0) begin
        burst_o.bytes[5] = payload_byte_i;
        crc_run          = crc_pl;
        if (last_item_i) begin
          burst_o.bytes[6] = crc_pl[15:8];
          burst_o.bytes[7] = crc_pl[7:0];
          burst_o.count    = CntW'(8);
          burst_o.close    = 1'b1;
        end else begin
          burst_o.count = CntW'(6);
        end
      end else begin
        // empty payload closes at once
        crc_run          = crc_hdr;
        burst_o.bytes[5] = crc_hdr[15:8];
        burst_o.bytes[6] = crc_hdr[7:0];
        burst_o.count    = CntW'(7);
        burst_o.close    = 1'b1;
      end
    end else if (in_frame_q) begin
      burst_o.bytes[0] = payload_byte_i;
      if (last_item_i) begin
        burst_o.bytes[1] = crc_pl[15:8];
        burst_o.bytes[2] = crc_pl[7:0];
        burst_o.count    = CntW'(3);
        burst_o.close    = 1'b1;
      end else begin
        burst_o.count = CntW'(1);
      end
    end
  end

  assign active = first_item_i || in_frame_q;

  always_comb begin
    crc_d      = crc_q;
    in_frame_d = in_frame_q;
    if (accept_i && active) begin
      if (burst_o.close) begin
        crc_d      = CrcInit;
        in_frame_d = 1'b0;
      end else begin
        crc_d      = crc_run;
        in_frame_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      in_frame_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

/* rtl/cfe_burst.sv */
// output register for one item's byte run; shifts out a byte a cycle while ready_i is high
// depends on cfe_pkg
module cfe_burst (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  cfe_pkg::burst_t           burst_i,
  output logic                      load_ready_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [cfe_pkg::ByteW-1:0] frame_byte_o,
  output logic                      run_last_o,
  output logic                      frame_last_o
);
  import cfe_pkg::*;

  logic [BurstMax-1:0][ByteW-1:0] bytes_q, bytes_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           close_q, close_d;
  logic                           take;
  logic                           at_last;

  assign valid_o      = (cnt_q != '0);
  assign at_last      = (cnt_q == CntW'(1));
  assign take         = valid_o && ready_i;
  assign load_ready_o = !valid_o || (at_last && ready_i);
  assign frame_byte_o = bytes_q[0];
  assign run_last_o   = at_last;
  assign frame_last_o = at_last && close_q;

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    close_d = close_q;
    if (load_i) begin
      bytes_d = burst_i.bytes;
      cnt_d   = burst_i.count;
      close_d = burst_i.close;
    end else if (take) begin
      bytes_d = {ByteW'(0), bytes_q[BurstMax-1:1]};
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      close_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      close_q <= close_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

/* rtl/command_frame_encoder_crc16_top.sv */
// top level of the command frame encoder with crc-16 (poly 0x1021, init 0)
// depends on cfe_pkg, cfe_in_if, cfe_out_if, cfe_build, cfe_burst
//
//   channel  dir  fields                                              one item is
//   in_i     in   command payload_length payload_byte first/last_item  one frame step
//   out_o    out  frame_byte run_last frame_last                       one frame byte
//
// an item is taken in the cycle it is offered when the output register is empty
// or its last byte leaves; its bytes then leave one per cycle while out_o.ready
// is high, 1 to 8 of them, none for an item outside a frame
// later non-last items give one byte, so a stream of them runs at one item a cycle
// the output register holds its run while out_o.ready is low and in_i waits
// reset clears the crc, the open-frame flag and the output register
module command_frame_encoder_crc16_top #(
  parameter int unsigned MAX_PAYLOAD = cfe_pkg::MaxPayloadDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfe_in_if.sink    in_i,
  cfe_out_if.source out_o
);
  import cfe_pkg::*;

  burst_t burst;
  logic   accept;
  logic   load_ready;

  assign in_i.ready = load_ready;
  assign accept     = in_i.valid && load_ready;

  cfe_build #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_build (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .command_i       (in_i.command),
    .payload_length_i(in_i.payload_length),
    .payload_byte_i  (in_i.payload_byte),
    .first_item_i    (in_i.first_item),
    .last_item_i     (in_i.last_item),
    .burst_o         (burst)
  );

  cfe_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (burst.count != '0)),
    .burst_i     (burst),
    .load_ready_o(load_ready),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .frame_byte_o(out_o.frame_byte),
    .run_last_o  (out_o.run_last),
    .frame_last_o(out_o.frame_last)
  );

endmodule
